// File: rtl/core/scpa_pkg.sv
// Shared types and constants of the size class pool allocator.
package scpa_pkg;

   // Fixed geometry of the class pools.
   localparam int unsigned SLOTS = 16;
   localparam int unsigned SLOT_W = 4;
   localparam int unsigned CLASS_W = 4;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned SIZE_W = 24;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned MAX_CLASSES = 8;

   localparam logic [CLASS_W-1:0] SYSTEM_CLASS = 4'd8;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FREED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERSIZE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BADFREE = 3'd5;
   localparam logic [STATUS_W-1:0] ST_SYSTEM = 3'd6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SIZES_LOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZES_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITIES = 2'd2;

   // Kinds of work the front hands to the back.
   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_FREE = 2'd1;
   localparam logic [1:0] KIND_DIRECT = 2'd2;

   // Classified item passed from the front to the back.
   typedef struct packed {
      logic [1:0] kind;
      logic [STATUS_W-1:0] status;
      logic [CLASS_W-1:0] cls;
      logic [SLOT_W-1:0] index;
      logic [COUNT_W-1:0] cap;
   } work_type;

endpackage

// File: rtl/core/scpa_front.sv
// Front part: classifies each item and picks the size class.
module scpa_front #(
   parameter int unsigned NUM_CLASSES = 8,
   parameter int unsigned BLOCKS_PER_CLASS = 16,
   parameter int unsigned HEADER_BYTES = 16
) (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input logic operation,
   input logic [scpa_pkg::SIZE_W-1:0] request_size,
   input logic [scpa_pkg::CLASS_W-1:0] handle_class,
   input logic [scpa_pkg::SLOT_W-1:0] handle_index,
   input logic [63:0] sizes_low,
   input logic [63:0] sizes_high,
   input logic [63:0] capacities,
   output logic out_valid,
   input logic out_ready,
   output scpa_pkg::work_type out_work
);

   logic valid_ff, valid_in;
   scpa_pkg::work_type work_ff, work_in;
   logic [scpa_pkg::SIZE_W:0] need;
   logic found;
   logic [scpa_pkg::CLASS_W-1:0] pick;
   logic [7:0] cap_raw;
   logic [scpa_pkg::COUNT_W-1:0] cap_lim;

   localparam int unsigned CAP_MAX =
      (BLOCKS_PER_CLASS < scpa_pkg::SLOTS) ? BLOCKS_PER_CLASS : scpa_pkg::SLOTS;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work = work_ff;
   assign need = {1'b0, request_size} + (scpa_pkg::SIZE_W+1)'(HEADER_BYTES);

   // Lowest class whose block size holds the request plus header.
   always_comb begin
      logic [15:0] sz;
      found = 1'b0;
      pick = '0;
      for (int c = scpa_pkg::MAX_CLASSES - 1; c >= 0; c--) begin
         sz = (c < 4) ? sizes_low[16*(c%4) +: 16] : sizes_high[16*(c%4) +: 16];
         if (c < int'(NUM_CLASSES) && {9'd0, sz} >= need) begin
            found = 1'b1;
            pick = scpa_pkg::CLASS_W'(c);
         end
      end
   end

   // Effective capacity of the chosen class.
   always_comb begin
      cap_raw = capacities[8*pick[2:0] +: 8];
      if (cap_raw > 8'(CAP_MAX)) begin
         cap_lim = scpa_pkg::COUNT_W'(CAP_MAX);
      end else begin
         cap_lim = cap_raw[scpa_pkg::COUNT_W-1:0];
      end
   end

   // Classify the incoming item.
   always_comb begin
      work_in = work_ff;
      valid_in = valid_ff && !out_ready;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         work_in.cap = cap_lim;
         work_in.index = handle_index;
         work_in.cls = handle_class;
         work_in.status = scpa_pkg::ST_GRANTED;
         if (!operation) begin
            work_in.index = '0;
            if (request_size == '0) begin
               work_in.kind = scpa_pkg::KIND_DIRECT;
               work_in.status = scpa_pkg::ST_ZERO;
               work_in.cls = '0;
            end else if (!found) begin
               work_in.kind = scpa_pkg::KIND_DIRECT;
               work_in.status = scpa_pkg::ST_OVERSIZE;
               work_in.cls = scpa_pkg::SYSTEM_CLASS;
            end else begin
               work_in.kind = scpa_pkg::KIND_ALLOC;
               work_in.cls = pick;
            end
         end else if (handle_class == scpa_pkg::SYSTEM_CLASS) begin
            work_in.kind = scpa_pkg::KIND_DIRECT;
            work_in.status = scpa_pkg::ST_SYSTEM;
         end else if (32'(handle_class) >= NUM_CLASSES) begin
            work_in.kind = scpa_pkg::KIND_DIRECT;
            work_in.status = scpa_pkg::ST_BADFREE;
         end else begin
            work_in.kind = scpa_pkg::KIND_FREE;
            work_in.status = scpa_pkg::ST_FREED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      work_ff <= work_in;
   end

endmodule

// File: rtl/core/scpa_back.sv
// Back part: per-class queues, counters and flags; produces results.
module scpa_back #(
   parameter int unsigned NUM_CLASSES = 8
) (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input scpa_pkg::work_type in_work,
   output logic rsp_valid,
   output logic [scpa_pkg::STATUS_W-1:0] rsp_status,
   output logic [scpa_pkg::CLASS_W-1:0] rsp_block_class,
   output logic [scpa_pkg::SLOT_W-1:0] rsp_block_index,
   output logic [scpa_pkg::COUNT_W-1:0] rsp_class_in_use,
   output logic [scpa_pkg::COUNT_W-1:0] rsp_class_peak
);

   localparam int unsigned NC = NUM_CLASSES;
   localparam int unsigned CI_W = (NC > 1) ? $clog2(NC) : 1;
   localparam int unsigned SW = scpa_pkg::SLOT_W;
   localparam int unsigned CW = scpa_pkg::COUNT_W;

   // Sequencer states: fetch queue head, then update.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;

   logic [1:0] state_ff, state_in;
   scpa_pkg::work_type work_ff, work_in;

   logic [SW-1:0] queue_mem [NC*scpa_pkg::SLOTS];
   logic [SW-1:0] qrd_ff;

   logic [SW-1:0] head_ff [NC];
   logic [SW-1:0] tail_ff [NC];
   logic [CW-1:0] rcount_ff [NC];
   logic [CW-1:0] fresh_ff [NC];
   logic [CW-1:0] used_ff [NC];
   logic [CW-1:0] peak_ff [NC];
   logic [scpa_pkg::SLOTS-1:0] flag_ff [NC];

   logic rv_ff;
   logic [scpa_pkg::STATUS_W-1:0] st_ff;
   logic [scpa_pkg::CLASS_W-1:0] cls_ff;
   logic [SW-1:0] idx_ff;
   logic [CW-1:0] use_ff, pk_ff;

   logic [CI_W-1:0] ci;

   assign ci = CI_W'(work_ff.cls);
   assign in_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_block_class = cls_ff;
   assign rsp_block_index = idx_ff;
   assign rsp_class_in_use = use_ff;
   assign rsp_class_peak = pk_ff;

   always_comb begin
      state_in = state_ff;
      work_in = work_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               work_in = in_work;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Queue memory: read the class head, written on a valid free.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         qrd_ff <= queue_mem[{CI_W'(in_work.cls), head_ff[CI_W'(in_work.cls)]}];
      end
      if (state_ff == S_READ && work_ff.kind == scpa_pkg::KIND_FREE &&
          flag_ff[ci][work_ff.index]) begin
         queue_mem[{ci, tail_ff[ci]}] <= work_ff.index;
      end
   end

   always_ff @(posedge clock) begin
      logic [SW-1:0] idx;
      logic ok;
      logic [CW-1:0] used_n, peak_n;
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         for (int c = 0; c < int'(NC); c++) begin
            head_ff[c] <= '0;
            tail_ff[c] <= '0;
            rcount_ff[c] <= '0;
            fresh_ff[c] <= '0;
            used_ff[c] <= '0;
            peak_ff[c] <= '0;
            flag_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         work_ff <= work_in;
         rv_ff <= 1'b0;
         if (state_ff == S_READ) begin
            rv_ff <= 1'b1;
            st_ff <= work_ff.status;
            cls_ff <= work_ff.cls;
            idx_ff <= work_ff.index;
            use_ff <= '0;
            pk_ff <= '0;
            case (work_ff.kind)
               scpa_pkg::KIND_ALLOC: begin
                  ok = 1'b1;
                  idx = '0;
                  if (rcount_ff[ci] != '0) begin
                     idx = qrd_ff;
                     head_ff[ci] <= head_ff[ci] + 1'b1;
                     rcount_ff[ci] <= rcount_ff[ci] - 1'b1;
                  end else if (fresh_ff[ci] < work_ff.cap) begin
                     idx = fresh_ff[ci][SW-1:0];
                     fresh_ff[ci] <= fresh_ff[ci] + 1'b1;
                  end else begin
                     ok = 1'b0;
                  end
                  if (ok) begin
                     used_n = (used_ff[ci] < CW'(scpa_pkg::SLOTS)) ?
                        used_ff[ci] + 1'b1 : used_ff[ci];
                     peak_n = (used_n > peak_ff[ci]) ? used_n : peak_ff[ci];
                     flag_ff[ci][idx] <= 1'b1;
                     used_ff[ci] <= used_n;
                     peak_ff[ci] <= peak_n;
                     idx_ff <= idx;
                     use_ff <= used_n;
                     pk_ff <= peak_n;
                  end else begin
                     st_ff <= scpa_pkg::ST_EXHAUSTED;
                     idx_ff <= '0;
                     use_ff <= used_ff[ci];
                     pk_ff <= peak_ff[ci];
                  end
               end
               scpa_pkg::KIND_FREE: begin
                  if (flag_ff[ci][work_ff.index]) begin
                     used_n = (used_ff[ci] != '0) ? used_ff[ci] - 1'b1 : used_ff[ci];
                     flag_ff[ci][work_ff.index] <= 1'b0;
                     tail_ff[ci] <= tail_ff[ci] + 1'b1;
                     if (rcount_ff[ci] < CW'(scpa_pkg::SLOTS)) begin
                        rcount_ff[ci] <= rcount_ff[ci] + 1'b1;
                     end
                     used_ff[ci] <= used_n;
                     use_ff <= used_n;
                  end else begin
                     st_ff <= scpa_pkg::ST_BADFREE;
                     use_ff <= used_ff[ci];
                  end
                  pk_ff <= peak_ff[ci];
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// File: rtl/core/size_class_pool_allocator_core.sv
// Top level of the size class pool allocator.
//
//  channel  | ports                          | handshake
//  request  | req_operation .. handle_index  | start && !busy
//  response | rsp_status .. rsp_class_peak   | rsp_valid, one cycle
//  config   | csr_index, csr_data            | csr_valid && csr_ready
//
// An item passes the back sequencer in order (queue memory read, then
// the counter update); the back takes no new item until it is done.
// A result passes the front register, the back sequencer and the result
// registers before it reaches the ports. The front register can hold one
// item while the back works. Reset is synchronous; the response side
// cannot stall.
module size_class_pool_allocator_core #(
   parameter int unsigned NUM_CLASSES = 8,
   parameter int unsigned BLOCKS_PER_CLASS = 16,
   parameter int unsigned HEADER_BYTES = 16
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic req_operation,
   input logic [23:0] req_request_size,
   input logic [3:0] req_handle_class,
   input logic [3:0] req_handle_index,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [3:0] rsp_block_class,
   output logic [3:0] rsp_block_index,
   output logic [4:0] rsp_class_in_use,
   output logic [4:0] rsp_class_peak,
   input logic csr_valid,
   output logic csr_ready,
   input logic [1:0] csr_index,
   input logic [63:0] csr_data
);

   logic [63:0] sizes_low_ff, sizes_high_ff, caps_ff;
   logic in_ready, mid_valid, mid_ready;
   scpa_pkg::work_type mid_work;

   assign busy = !in_ready;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sizes_low_ff <= 64'd117094592909815872;
         sizes_high_ff <= 64'd1125912791880303616;
         caps_ff <= 64'd34494482440;
      end else if (csr_valid) begin
         case (csr_index)
            scpa_pkg::CSR_SIZES_LOW: sizes_low_ff <= csr_data;
            scpa_pkg::CSR_SIZES_HIGH: sizes_high_ff <= csr_data;
            scpa_pkg::CSR_CAPACITIES: caps_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   scpa_front #(
      .NUM_CLASSES(NUM_CLASSES),
      .BLOCKS_PER_CLASS(BLOCKS_PER_CLASS),
      .HEADER_BYTES(HEADER_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(start),
      .in_ready(in_ready),
      .operation(req_operation),
      .request_size(req_request_size),
      .handle_class(req_handle_class),
      .handle_index(req_handle_index),
      .sizes_low(sizes_low_ff),
      .sizes_high(sizes_high_ff),
      .capacities(caps_ff),
      .out_valid(mid_valid),
      .out_ready(mid_ready),
      .out_work(mid_work)
   );

   scpa_back #(
      .NUM_CLASSES(NUM_CLASSES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(mid_valid),
      .in_ready(mid_ready),
      .in_work(mid_work),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_block_class(rsp_block_class),
      .rsp_block_index(rsp_block_index),
      .rsp_class_in_use(rsp_class_in_use),
      .rsp_class_peak(rsp_class_peak)
   );

`ifndef SYNTHESIS
   // A result follows the back taking an item, once the sequencer has passed its read state.
   a_rsp_after_take: assert property (@(posedge clock) disable iff (reset)
      mid_valid && mid_ready |=> ##1 rsp_valid) else $error("missing result");
   // Results are never back to back.
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("results too close");
   // Peak never below in-use on a result.
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_class_peak >= rsp_class_in_use) else $error("peak low");
`endif

endmodule

// File: tb/sv/tb_size_class_pool_allocator_core.sv
// Self-checking testbench for the size class pool allocator core.
`timescale 1ns / 1ps

module tb_size_class_pool_allocator_core;

   localparam int unsigned N_CLASSES = 8;
   localparam int unsigned BLOCKS = 16;
   localparam int unsigned HDR = 16;
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;
   localparam logic [63:0] RST_SIZES_LOW = 64'd117094592909815872;
   localparam logic [63:0] RST_SIZES_HIGH = 64'd1125912791880303616;
   localparam logic [63:0] RST_CAPS = 64'd34494482440;

   // One result item.
   typedef struct packed {
      logic [scpa_pkg::STATUS_W-1:0] status;
      logic [scpa_pkg::CLASS_W-1:0] cls;
      logic [scpa_pkg::SLOT_W-1:0] index;
      logic [scpa_pkg::COUNT_W-1:0] in_use;
      logic [scpa_pkg::COUNT_W-1:0] peak;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_operation = 1'b0;
   logic [23:0] req_request_size = '0;
   logic [3:0] req_handle_class = '0;
   logic [3:0] req_handle_index = '0;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [3:0] rsp_block_class;
   logic [3:0] rsp_block_index;
   logic [4:0] rsp_class_in_use;
   logic [4:0] rsp_class_peak;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   size_class_pool_allocator_core #(
      .NUM_CLASSES(N_CLASSES),
      .BLOCKS_PER_CLASS(BLOCKS),
      .HEADER_BYTES(HDR)
   ) dut (.*);

   always #5 clock = ~clock;

   // Mirror of the allocator state.
   logic [63:0] sizes_low, sizes_high, caps;
   logic [3:0] free_fifo [N_CLASSES][scpa_pkg::SLOTS];
   logic [3:0] fifo_head [N_CLASSES];
   logic [3:0] fifo_tail [N_CLASSES];
   logic [4:0] fifo_count [N_CLASSES];
   logic [4:0] fresh_next [N_CLASSES];
   logic [4:0] in_use [N_CLASSES];
   logic [4:0] peak [N_CLASSES];
   logic [15:0] owned [N_CLASSES];

   grant_type expected_grants [$];
   int mismatches = 0;
   bit quiet = 1'b0;

   function automatic int unsigned class_size(int unsigned c);
      logic [63:0] w;
      w = (c < 4) ? sizes_low : sizes_high;
      return 32'((w >> (16 * (c % 4))) & 64'hFFFF);
   endfunction

   function automatic int unsigned class_cap(int unsigned c);
      int unsigned v;
      v = 32'((caps >> (8 * c)) & 64'hFF);
      if (v > BLOCKS) v = BLOCKS;
      if (v > scpa_pkg::SLOTS) v = scpa_pkg::SLOTS;
      return v;
   endfunction

   // Computes the result of one item and updates the mirror.
   function automatic grant_type allocator_step(logic op, logic [23:0] sz,
                                                logic [3:0] hc, logic [3:0] hi);
      grant_type g;
      int unsigned need, c, idx;
      bit found;
      g = '0;
      found = 1'b0;
      if (op == OP_ALLOC) begin
         need = 32'(sz) + HDR;
         if (sz == 0) begin
            g.status = scpa_pkg::ST_ZERO;
            return g;
         end
         for (c = 0; c < N_CLASSES; c++) begin
            if (class_size(c) >= need) begin
               found = 1'b1;
               break;
            end
         end
         if (!found) begin
            g.status = scpa_pkg::ST_OVERSIZE;
            g.cls = scpa_pkg::SYSTEM_CLASS;
            return g;
         end
         g.cls = scpa_pkg::CLASS_W'(c);
         if (fifo_count[c] > 0) begin
            idx = 32'(free_fifo[c][fifo_head[c]]);
            fifo_head[c] = fifo_head[c] + 1'b1;
            fifo_count[c] = fifo_count[c] - 1'b1;
         end else if (fresh_next[c] < class_cap(c)) begin
            idx = 32'(fresh_next[c][3:0]);
            fresh_next[c] = fresh_next[c] + 1'b1;
         end else begin
            g.status = scpa_pkg::ST_EXHAUSTED;
            g.in_use = in_use[c];
            g.peak = peak[c];
            return g;
         end
         owned[c][idx] = 1'b1;
         if (in_use[c] < scpa_pkg::SLOTS) in_use[c] = in_use[c] + 1'b1;
         if (in_use[c] > peak[c]) peak[c] = in_use[c];
         g.status = scpa_pkg::ST_GRANTED;
         g.index = scpa_pkg::SLOT_W'(idx);
         g.in_use = in_use[c];
         g.peak = peak[c];
      end else begin
         g.cls = hc;
         g.index = hi;
         if (hc == scpa_pkg::SYSTEM_CLASS) begin
            g.status = scpa_pkg::ST_SYSTEM;
            return g;
         end
         if (hc >= N_CLASSES) begin
            g.status = scpa_pkg::ST_BADFREE;
            return g;
         end
         g.in_use = in_use[hc];
         g.peak = peak[hc];
         if (!owned[hc][hi]) begin
            g.status = scpa_pkg::ST_BADFREE;
            return g;
         end
         owned[hc][hi] = 1'b0;
         free_fifo[hc][fifo_tail[hc]] = hi;
         fifo_tail[hc] = fifo_tail[hc] + 1'b1;
         if (fifo_count[hc] < scpa_pkg::SLOTS) fifo_count[hc] = fifo_count[hc] + 1'b1;
         if (in_use[hc] > 0) in_use[hc] = in_use[hc] - 1'b1;
         g.status = scpa_pkg::ST_FREED;
         g.in_use = in_use[hc];
         g.peak = peak[hc];
      end
      return g;
   endfunction

   // Sends one item, with random idle cycles before it unless idling is off.
   task automatic send_item(logic op, logic [23:0] sz, logic [3:0] hc, logic [3:0] hi);
      while (!quiet && $urandom_range(99) < 13) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_request_size <= sz;
      req_handle_class <= hc;
      req_handle_index <= hi;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_grants.push_back(allocator_step(op, sz, hc, hi));
      @(negedge clock);
   endtask

   task automatic alloc(logic [23:0] sz);
      send_item(OP_ALLOC, sz, 4'($urandom_range(15)), 4'($urandom_range(15)));
   endtask

   task automatic release_block(logic [3:0] hc, logic [3:0] hi);
      send_item(OP_FREE, 24'($urandom), hc, hi);
   endtask

   // Stops driving, then waits until every result is in and the back is quiet.
   task automatic drain();
      start <= 1'b0;
      csr_valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes one register; the following drain lowers the write strobe.
   task automatic write_csr(logic [1:0] idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         scpa_pkg::CSR_SIZES_LOW: sizes_low = data;
         scpa_pkg::CSR_SIZES_HIGH: sizes_high = data;
         default: caps = data;
      endcase
      @(negedge clock);
   endtask

   // Picks a size that lands in a random class, or off the edges.
   function automatic logic [23:0] pick_size();
      int unsigned c, s;
      c = $urandom_range(N_CLASSES - 1);
      s = class_size(c);
      case ($urandom_range(9))
         0: return 24'($urandom);
         1: return 24'($urandom_range(3) + 1);
         default: return (s > HDR) ? 24'($urandom_range(s - HDR, 1)) : 24'd1;
      endcase
   endfunction

   // Compares each result with the oldest expectation.
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid) begin
         if (expected_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
         end else begin
            want = expected_grants.pop_front();
            if (want != {rsp_status, rsp_block_class, rsp_block_index,
                         rsp_class_in_use, rsp_class_peak}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected st=%0d cls=%0d idx=%0d use=%0d pk=%0d,",
                            " got st=%0d cls=%0d idx=%0d use=%0d pk=%0d"},
                           want.status, want.cls, want.index, want.in_use, want.peak,
                           rsp_status, rsp_block_class, rsp_block_index,
                           rsp_class_in_use, rsp_class_peak);
            end
         end
      end
   end

   // Edges of the fields and every special case.
   task automatic test_directed();
      alloc(24'd0);
      alloc(24'hFFFFFF);
      alloc(24'd1);
      alloc(24'd48);
      alloc(24'd49);
      release_block(4'd0, 4'd0);
      release_block(4'd0, 4'd0);
      release_block(4'd0, 4'd15);
      release_block(scpa_pkg::SYSTEM_CLASS, 4'd15);
      release_block(4'd15, 4'd9);
      release_block(4'd9, 4'd0);
      alloc(24'd1);
      release_block(4'd1, 4'd0);
      alloc(24'd3984);
      alloc(24'd3985);
   endtask

   // Fills a small class to exhaustion, then frees out of order.
   task automatic test_exhaust();
      write_csr(scpa_pkg::CSR_CAPACITIES, 64'h0000_0000_0000_0300);
      drain();
      repeat (5) alloc(24'd60);
      release_block(4'd1, 4'd2);
      release_block(4'd1, 4'd0);
      alloc(24'd60);
      alloc(24'd60);
      alloc(24'd60);
      alloc(24'd8);
      drain();
   endtask

   // Random mixes under several register settings.
   task automatic test_random(int items);
      int unsigned c;
      for (int n = 0; n < items; n++) begin
         quiet = (n >= items / 3) && (n < items / 2);
         c = $urandom_range(N_CLASSES - 1);
         case ($urandom_range(9))
            0, 1, 2, 3: alloc(pick_size());
            4, 5, 6, 7: release_block(4'(c), 4'($urandom_range(15)));
            8: release_block(4'($urandom_range(15)), 4'($urandom_range(15)));
            default: alloc($urandom_range(1) ? 24'd0 : 24'($urandom));
         endcase
      end
      quiet = 1'b0;
      drain();
   endtask

   task automatic test_settings();
      write_csr(scpa_pkg::CSR_SIZES_LOW, 64'hFFFF_0400_0100_0011);
      write_csr(scpa_pkg::CSR_SIZES_HIGH, 64'h0000_0000_FFFF_FFFF);
      write_csr(scpa_pkg::CSR_CAPACITIES, 64'hFF10_0F08_0201_00FF);
      drain();
      test_random(300);
      write_csr(scpa_pkg::CSR_SIZES_LOW, 64'd0);
      write_csr(scpa_pkg::CSR_SIZES_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(scpa_pkg::CSR_CAPACITIES, 64'hFFFF_FFFF_FFFF_FFFF);
      drain();
      test_random(200);
      write_csr(scpa_pkg::CSR_SIZES_LOW, RST_SIZES_LOW);
      write_csr(scpa_pkg::CSR_SIZES_HIGH, RST_SIZES_HIGH);
      write_csr(scpa_pkg::CSR_CAPACITIES, 64'h0404_0404_0404_0404);
      drain();
      test_random(250);
   endtask

   initial begin
      sizes_low = RST_SIZES_LOW;
      sizes_high = RST_SIZES_HIGH;
      caps = RST_CAPS;
      for (int c = 0; c < N_CLASSES; c++) begin
         fifo_head[c] = '0;
         fifo_tail[c] = '0;
         fifo_count[c] = '0;
         fresh_next[c] = '0;
         in_use[c] = '0;
         peak[c] = '0;
         owned[c] = '0;
         for (int s = 0; s < scpa_pkg::SLOTS; s++) free_fifo[c][s] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400);
      test_exhaust();
      test_settings();
      drain();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/core/scpa_pkg.sv
rtl/core/scpa_front.sv
rtl/core/scpa_back.sv
rtl/core/size_class_pool_allocator_core.sv
tb/sv/tb_size_class_pool_allocator_core.sv
